FILE: sv/bsrd_pkg.sv
`default_nettype none

package bsrd_pkg;

  // Channel limits; counts above these saturate on write (only the low count bits are compared)
  localparam int unsigned MAX_ANALOG  = 64;
  localparam int unsigned MAX_DIGITAL = 256;

  localparam int unsigned ACNT_W = 7;
  localparam int unsigned DCNT_W = 9;
  localparam int unsigned STOP_W = 31;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned ADDR_W = 4;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_ANALOG_COUNT  = 2'd0,
    REG_DIGITAL_COUNT = 2'd1,
    REG_STOP_SAMPLE   = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_TSTAMP  = 2'd1,
    KIND_ANALOG  = 2'd2,
    KIND_DIGITAL = 2'd3
  } kind_t;

endpackage

`default_nettype wire

FILE: sv/binary_sample_record_deframer.sv
// Channel  | Direction | Handshake                 | Payload
// in_      | input     | in_valid / in_ready       | in_data_byte[7:0]
// out_     | output    | out_valid / out_ready     | kind, channel, value, last, stop
// cfg_     | input     | APB psel/penable/pready   | paddr[3:0], pwdata/prdata[31:0]
//
// A byte is decoded in the cycle it is accepted and its results land in a
// result buffer; one result per cycle moves to the output register unless stalled.
// Bytes giving zero or one result are taken every cycle unless stalled; a digital
// byte gives up to eight results and holds in_ready low until its last one moves.
// Reset (rst_n, synchronous) clears registers, record position and stop state.
// A stalled output holds the output register, then the result buffer, then input.
`default_nettype none

module binary_sample_record_deframer (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // byte input
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   in_data_byte,
  // result output
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output bsrd_pkg::kind_t                   out_kind,
  output logic [7:0]                        out_channel,
  output logic signed [31:0]                out_value,
  output logic                              out_last_of_record,
  output logic                              out_stop_reached,
  // configuration
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [bsrd_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  import bsrd_pkg::*;

  // configuration registers
  logic [ACNT_W-1:0] acnt_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [STOP_W-1:0] stop_r;

  // record state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [23:0]       wa_r, wa_nxt;
  logic              stop_pend_r, stop_pend_nxt;
  logic              done_r, done_nxt;

  // result buffer (decoded item)
  logic [3:0]        item_cnt_r, item_cnt_nxt;
  logic [2:0]        item_idx_r;
  kind_t             item_kind_r, item_kind_nxt;
  logic [7:0]        item_chan_r, item_chan_nxt;
  logic [31:0]       item_value_r, item_value_nxt;
  logic              item_last_r, item_last_nxt;
  logic              item_stop_r, item_stop_nxt;

  // output register
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [7:0]        out_chan_r;
  logic [31:0]       out_value_r;
  logic              out_last_r;
  logic              out_stop_r;

  logic              in_acc;
  logic              move;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register read mux
  always_comb begin
    unique case (cfg_idx)
      REG_ANALOG_COUNT:  cfg_prdata = {{(32-ACNT_W){1'b0}}, acnt_r};
      REG_DIGITAL_COUNT: cfg_prdata = {{(32-DCNT_W){1'b0}}, dcnt_r};
      REG_STOP_SAMPLE:   cfg_prdata = {{(32-STOP_W){1'b0}}, stop_r};
      default:           cfg_prdata = 32'd0;
    endcase
  end

  // register writes, counts saturate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acnt_r <= '0;
      dcnt_r <= '0;
      stop_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ANALOG_COUNT: begin
          if (cfg_pwdata[ACNT_W-1:0] > ACNT_W'(MAX_ANALOG)) acnt_r <= ACNT_W'(MAX_ANALOG);
          else acnt_r <= cfg_pwdata[ACNT_W-1:0];
        end
        REG_DIGITAL_COUNT: begin
          if (cfg_pwdata[DCNT_W-1:0] > DCNT_W'(MAX_DIGITAL)) dcnt_r <= DCNT_W'(MAX_DIGITAL);
          else dcnt_r <= cfg_pwdata[DCNT_W-1:0];
        end
        REG_STOP_SAMPLE: stop_r <= cfg_pwdata[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes; no input is taken while reset is held
  assign move     = (item_cnt_r != 4'd0) && (!out_valid_r || out_ready);
  assign in_ready = rst_n && ((item_cnt_r == 4'd0) || (move && item_cnt_r == 4'd1));
  assign in_acc   = in_valid && in_ready;

  // byte decode: record layout, field assembly, result buffer load
  always_comb begin
    logic [POS_W-1:0] analog_end;
    logic [POS_W-1:0] rec_len;
    logic [4:0]       dwords;
    logic [POS_W:0]   pos_inc;
    logic [POS_W-1:0] aoff;
    logic [POS_W-1:0] doff;
    logic [7:0]       base;
    logic [DCNT_W-1:0] rem;
    logic [31:0]      word;
    logic [15:0]      raw;
    logic [7:0]       ach;
    logic [7:0]       b;

    b          = in_data_byte;
    analog_end = POS_W'(8) + {1'b0, acnt_r, 1'b0};
    dwords     = 5'((DCNT_W+1)'(dcnt_r) + (DCNT_W+1)'(15) >> 4);
    rec_len    = analog_end + POS_W'({dwords, 1'b0});
    pos_inc    = {1'b0, pos_r} + (POS_W+1)'(1);
    aoff       = pos_r - POS_W'(8);
    doff       = pos_r - analog_end;
    base       = {doff[4:0], 3'b000};
    rem        = dcnt_r - DCNT_W'(base);
    word       = {b, wa_r};
    raw        = {b, wa_r[7:0]};
    ach        = 8'(aoff >> 1);

    pos_nxt        = pos_r;
    wa_nxt         = wa_r;
    stop_pend_nxt  = stop_pend_r;
    done_nxt       = done_r;
    item_cnt_nxt   = 4'd0;
    item_kind_nxt  = KIND_SAMPLE;
    item_chan_nxt  = 8'd0;
    item_value_nxt = word;
    item_last_nxt  = 1'b0;
    item_stop_nxt  = stop_pend_r;

    if (!done_r) begin
      priority if (pos_r < POS_W'(8)) begin
        // sample number and timestamp, little endian
        unique case (pos_r[1:0])
          2'd0: wa_nxt = {16'd0, b};
          2'd1: wa_nxt = wa_r | {8'd0, b, 8'd0};
          2'd2: wa_nxt = wa_r | {b, 16'd0};
          default: begin
            item_cnt_nxt = 4'd1;
            if (pos_r[2] == 1'b0) begin
              stop_pend_nxt = (word == {1'b0, stop_r});
              item_stop_nxt = stop_pend_nxt;
              item_kind_nxt = KIND_SAMPLE;
            end else begin
              item_kind_nxt = KIND_TSTAMP;
              item_last_nxt = (acnt_r == '0) && (dcnt_r == '0);
            end
          end
        endcase
      end else if (pos_r < analog_end) begin
        // analog words, sign extended
        if (!pos_r[0]) begin
          wa_nxt = {16'd0, b};
        end else begin
          item_cnt_nxt   = 4'd1;
          item_kind_nxt  = KIND_ANALOG;
          item_chan_nxt  = ach;
          item_value_nxt = {{16{raw[15]}}, raw};
          item_last_nxt  = (dcnt_r == '0) && ((ach + 8'd1) == 8'(acnt_r));
        end
      end else if (pos_r < rec_len) begin
        // digital byte: bits below the channel count, LSB first
        item_kind_nxt  = KIND_DIGITAL;
        item_chan_nxt  = base;
        item_value_nxt = {24'd0, b};
        if (dcnt_r > DCNT_W'(base)) begin
          item_cnt_nxt  = (rem >= DCNT_W'(8)) ? 4'd8 : rem[3:0];
          item_last_nxt = (rem <= DCNT_W'(8));
        end
      end else begin
        // past the record end: no result
      end

      // end of record
      if (pos_inc >= {1'b0, rec_len}) begin
        pos_nxt       = '0;
        done_nxt      = stop_pend_nxt;
        stop_pend_nxt = 1'b0;
      end else begin
        pos_nxt = pos_inc[POS_W-1:0];
      end
    end
  end

  // record state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      wa_r        <= '0;
      stop_pend_r <= 1'b0;
      done_r      <= 1'b0;
    end else if (in_acc) begin
      pos_r       <= pos_nxt;
      wa_r        <= wa_nxt;
      stop_pend_r <= stop_pend_nxt;
      done_r      <= done_nxt;
    end
  end

  // result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_cnt_r <= 4'd0;
      item_idx_r <= 3'd0;
    end else if (in_acc) begin
      item_cnt_r <= item_cnt_nxt;
      item_idx_r <= 3'd0;
    end else if (move) begin
      item_cnt_r <= item_cnt_r - 4'd1;
      item_idx_r <= item_idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_kind_r  <= item_kind_nxt;
      item_chan_r  <= item_chan_nxt;
      item_value_r <= item_value_nxt;
      item_last_r  <= item_last_nxt;
      item_stop_r  <= item_stop_nxt;
    end
  end

  // output register, one result per cycle unless the output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_kind_r <= item_kind_r;
      if (item_kind_r == KIND_DIGITAL) begin
        out_chan_r  <= item_chan_r + {5'd0, item_idx_r};
        out_value_r <= {31'd0, item_value_r[item_idx_r]};
      end else begin
        out_chan_r  <= item_chan_r;
        out_value_r <= item_value_r;
      end
      out_last_r <= item_last_r && (item_cnt_r == 4'd1);
      out_stop_r <= item_last_r && (item_cnt_r == 4'd1) && item_stop_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_channel        = out_chan_r;
  assign out_value          = out_value_r;
  assign out_last_of_record = out_last_r;
  assign out_stop_reached   = out_stop_r;

`ifndef ASSERT_OFF
  // a byte with several results pending blocks new input
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (item_cnt_r > 4'd1) |-> !in_ready)
    else $error("input taken while result buffer busy");

  // the buffer never holds more than one byte's worth of bits
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    item_cnt_r <= 4'd8)
    else $error("result buffer count out of range");

  // stop flag only on the last result of a record
  a_stop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stop_reached) |-> out_last_of_record)
    else $error("stop flag without last flag");

  // once the stream has ended it stays ended
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("stream end cleared without reset");

  // nothing new enters the buffer after the stream has ended
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && in_acc) |=> (item_cnt_r == 4'd0))
    else $error("result produced after stream end");
`endif

endmodule

`default_nettype wire
